### design/aes128_cfb_multi_session_macros.svh
// Assertion macros used by the top-level design file
`ifndef AES128_CFB_MULTI_SESSION_MACROS_SVH
`define AES128_CFB_MULTI_SESSION_MACROS_SVH

// implication checked on every clock edge outside reset
`define ACFB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ACFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/acfb_pkg.sv
// Package: payload types, codes and AES helper functions
`default_nettype none
package acfb_pkg;

  localparam int unsigned Sessions = 4;
  localparam int unsigned SesW = 2;
  localparam int unsigned RkDepth = Sessions * 44;
  localparam int unsigned RkAw = $clog2(RkDepth);
  localparam int unsigned CvDepth = Sessions * 2;
  localparam int unsigned CvAw = $clog2(CvDepth);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENC    = 2'd1;
  localparam logic [1:0] OP_DEC    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic CFG_IV_HIGH = 1'b0;
  localparam logic CFG_IV_LOW  = 1'b1;

  typedef struct packed {
    logic [1:0]      op;
    logic [SesW-1:0] session;
    logic [63:0]     data_high;
    logic [63:0]     data_low;
    logic            message_end;
  } in_item_t;

  typedef struct packed {
    logic [63:0]     result_high;
    logic [63:0]     result_low;
    logic [SesW-1:0] session_out;
    logic            message_end_out;
  } out_item_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // one full round: sub bytes, shift rows, optional mix columns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[4*c+i] = sbox(b[4*((c+i)%4)+i]);
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o;
  endfunction

endpackage
`default_nettype wire

### design/aes128_cfb_multi_session.sv
// Top level: multi-session AES-128 CFB-128 engine around key and chaining memories
//
//  channel | direction | handshake            | payload
//  in      | in        | in_valid / in_ready   | in_item_t
//  out     | out       | out_valid / out_ready | out_item_t
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A block runs through two chaining-value reads, then the whitening and ten rounds,
// one 128-bit round key row read per round from the key memory, then the output
// step. A key load writes one round key row per cycle, 11 rows in all. Reset clears
// control and sets the IV registers to their default values; memories need a key
// load per session before use. One item is in flight at a time; a block stalls in
// its output step only while the previous result still waits in the output register.
`default_nettype none
`include "aes128_cfb_multi_session_macros.svh"
module aes128_cfb_multi_session
  import acfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire in_item_t    in_data,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      out_item_t   out_data,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int unsigned RowAw = $clog2(Sessions * 11);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KEY  = 3'd1;
  localparam logic [2:0] ST_CV   = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]   state;
  logic [3:0]   rnd;
  in_item_t     item;
  logic [63:0]  iv_high, iv_low;
  logic [127:0] blk;
  logic [127:0] prev_key;
  logic [63:0]  cv_hi;

  // round key memory: one 128-bit row per round (four words)
  logic [127:0] rk_mem [Sessions*11];
  logic [127:0] rk_rd;
  logic [RowAw-1:0] rk_raddr, rk_waddr;
  logic         rk_we;
  logic [127:0] rk_wdata;

  logic [63:0]  cv_mem [CvDepth];
  logic [63:0]  cv_rd;
  logic [CvAw-1:0] cv_raddr, cv_waddr;
  logic         cv_we;
  logic [63:0]  cv_wdata;

  logic [127:0] ks, res;
  logic         take;
  logic         out_load;

  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
    rk_rd <= rk_mem[rk_raddr];
  end

  always_ff @(posedge clk) begin
    if (cv_we) cv_mem[cv_waddr] <= cv_wdata;
    cv_rd <= cv_mem[cv_raddr];
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;
  // output register free, or freed by the transaction at this edge
  assign out_load  = (state == ST_OUT) && (rnd == 4'd0) && (!out_valid || out_ready);

  // key expansion step: next row from the previous one
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] t, w0, w1, w2, w3;
    t = k[31:0];
    t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])} ^ {rcon(r), 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  logic [RowAw-1:0] row_base;
  assign row_base = RowAw'(item.session) * RowAw'(11);

  // rows are read in the cycle before use: row 0 during the cv reads, row rnd+1 in round rnd
  always_comb begin
    rk_raddr = row_base;
    if (state == ST_RND && rnd != 4'd10) rk_raddr = row_base + RowAw'(rnd) + RowAw'(1);
  end

  assign ks  = blk;
  assign res = ks ^ {item.data_high, item.data_low};

  always_comb begin
    cv_raddr = {item.session, 1'b0};
    if (state == ST_IDLE) cv_raddr = {in_data.session, 1'b0};
    else if (state == ST_CV) cv_raddr = {item.session, 1'b1};
  end

  always_comb begin
    rk_we = (state == ST_KEY);
    rk_waddr = row_base + RowAw'(rnd);
    rk_wdata = (rnd == 4'd0) ? {item.data_high, item.data_low} : key_step(prev_key, rnd);
  end

  // chaining write: during key load the IV, after a block the new cv
  logic [127:0] new_cv;
  assign new_cv = (item.op == OP_ENC) ? res : {item.data_high, item.data_low};
  always_comb begin
    cv_we = 1'b0;
    cv_waddr = {item.session, 1'b0};
    cv_wdata = iv_high;
    if (state == ST_KEY && rnd == 4'd0) begin
      cv_we = 1'b1;
    end else if (state == ST_KEY && rnd == 4'd1) begin
      cv_we = 1'b1;
      cv_waddr = {item.session, 1'b1};
      cv_wdata = iv_low;
    end else if (state == ST_OUT && rnd == 4'd0) begin
      cv_we = 1'b1;
      cv_wdata = new_cv[127:64];
    end else if (state == ST_OUT && rnd == 4'd1) begin
      cv_we = 1'b1;
      cv_waddr = {item.session, 1'b1};
      cv_wdata = new_cv[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv_high <= 64'h0001020304050607;
      iv_low  <= 64'h08090a0b0c0d0e0f;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IV_HIGH: iv_high <= cfg_data;
        CFG_IV_LOW:  iv_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (take && (in_data.op == OP_LOAD)) begin
            state <= ST_KEY;
            rnd <= '0;
          end else if (take && (in_data.op == OP_ENC || in_data.op == OP_DEC)) begin
            state <= ST_CV;
            rnd <= '0;
          end
        end
        ST_KEY: begin
          prev_key <= rk_wdata;
          if (rnd == 4'd10) state <= ST_IDLE;
          else rnd <= rnd + 4'd1;
        end
        ST_CV: begin
          // rnd 0: cv high on the read port; rnd 1: cv low and key row 0 follow
          if (rnd == 4'd0) begin
            cv_hi <= cv_rd;
            rnd <= 4'd1;
          end else begin
            rnd <= 4'd0;
            state <= ST_RND;
          end
        end
        ST_RND: begin
          // rnd 0: whitening with row 0 read during the cv reads
          if (rnd == 4'd0) blk <= {cv_hi, cv_rd} ^ rk_rd;
          else blk <= aes_round(blk, rnd != 4'd10) ^ rk_rd;
          if (rnd == 4'd10) begin
            state <= ST_OUT;
            rnd <= '0;
          end else begin
            rnd <= rnd + 4'd1;
          end
        end
        ST_OUT: begin
          if (rnd == 4'd0) begin
            if (out_load) begin
              out_data <= '{result_high: res[127:64], result_low: res[63:0],
                            session_out: item.session, message_end_out: item.message_end};
              rnd <= 4'd1;
            end
          end else begin
            rnd <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) item <= in_data;
  end

  `ACFB_ASSERT_IMP(a_no_accept_busy, state != ST_IDLE, !in_ready)
  `ACFB_ASSERT_IMP(a_rnd_range, state == ST_RND, rnd <= 4'd10)
  `ACFB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `ACFB_ASSERT_IMP(a_cv_write_owner, cv_we, state == ST_KEY || state == ST_OUT)

endmodule
`default_nettype wire
